// ===== src/aes_cbc_pkg.sv =====
`default_nettype none
package aes_cbc_pkg;

  localparam int unsigned BLK_BYTES = 16;
  localparam int unsigned ROUNDS    = 10;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_KEY_HIGH = 3'd0,
    REG_KEY_LOW  = 3'd1,
    REG_IV_HIGH  = 3'd2,
    REG_IV_LOW   = 3'd3,
    REG_MSG_LEN  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CONTINUE = 2'd0,
    ST_FINISHED = 2'd1,
    ST_FAIL     = 2'd2
  } status_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [0:9] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t, n0, n1, n2, n3;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // one cipher round; byte 0 sits in the top bits
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic fin);
    logic [7:0] sb [0:15];
    logic [7:0] n [0:15];
    logic [7:0] m [0:15];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      sb[i] = SBOX[s[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        n[j+4*c] = sb[j + 4*((c+j) % 4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = xt(n[4*c]) ^ xt(n[4*c+1]) ^ n[4*c+1] ^ n[4*c+2] ^ n[4*c+3];
      m[4*c+1] = n[4*c] ^ xt(n[4*c+1]) ^ xt(n[4*c+2]) ^ n[4*c+2] ^ n[4*c+3];
      m[4*c+2] = n[4*c] ^ n[4*c+1] ^ xt(n[4*c+2]) ^ xt(n[4*c+3]) ^ n[4*c+3];
      m[4*c+3] = xt(n[4*c]) ^ n[4*c] ^ n[4*c+1] ^ n[4*c+2] ^ xt(n[4*c+3]);
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = fin ? n[i] : m[i];
    end
    return r ^ rk;
  endfunction

endpackage
`default_nettype wire

// ===== src/aes_cbc_if.sv =====
`default_nettype none
interface aes_cbc_in_if;
  logic        valid;
  logic        ready;
  logic        start_message;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  modport source (output valid, start_message, plain_high, plain_low, input ready);
  modport sink (input valid, start_message, plain_high, plain_low, output ready);
endinterface

interface aes_cbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  logic [1:0]  status;
  logic        last_of_run;
  modport source (output valid, cipher_high, cipher_low, status, last_of_run, input ready);
  modport sink (input valid, cipher_high, cipher_low, status, last_of_run, output ready);
endinterface

interface aes_cbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/aes_cbc_padded_encrypt.sv =====
// an accepted word is encrypted combinationally and its result registered in the output register
// throughput: one word per cycle unless the output stalls or a pad block is owed, set by the
// fully unrolled 10-round aes datapath; a block that ends the message on a block boundary
// gives two results: the pad block reuses the same aes datapath after it while input is held off
// reset (rst, synchronous, active high) clears configuration, chain value, offset, pad flag and output controls
`default_nettype none
module aes_cbc_padded_encrypt (
  input  wire logic    clk,
  input  wire logic    rst,
  aes_cbc_in_if.sink   in_ch,
  aes_cbc_out_if.source out_ch,
  aes_cbc_cfg_if.sink  cfg_ch
);
  import aes_cbc_pkg::*;

  // configuration registers
  logic [127:0] key;
  logic [127:0] iv;
  logic [31:0]  msg_len;

  // chaining state
  logic [127:0] chain;
  logic [31:0]  offset;
  logic         pad_pending;

  // output register
  logic         out_valid;
  logic [127:0] out_data;
  status_t      out_status;
  logic         out_last;

  logic out_free, in_fire;
  logic [31:0]  off_eff;
  logic [32:0]  end_pos;
  logic         past_end, at_end, partial;
  logic [3:0]   rest;
  logic [7:0]   pad_val;
  logic [127:0] plain_pad, cv_sel, aes_in;
  logic [127:0] st [0:ROUNDS];
  logic [127:0] rk [0:ROUNDS];

  assign out_free     = !out_valid || out_ch.ready;
  assign in_ch.ready  = out_free && !pad_pending;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // offset bookkeeping for the incoming word
  assign off_eff  = in_ch.start_message ? 32'd0 : offset;
  assign past_end = off_eff >= msg_len;
  assign end_pos  = {1'b0, off_eff} + 33'(BLK_BYTES);
  assign at_end   = end_pos == {1'b0, msg_len};
  assign partial  = end_pos > {1'b0, msg_len};
  assign rest     = 4'(msg_len - off_eff);
  assign pad_val  = 8'(5'(BLK_BYTES) - {1'b0, rest});

  // pkcs padding of the final partial block
  always_comb begin
    plain_pad = {in_ch.plain_high, in_ch.plain_low};
    for (int i = 0; i < 16; i++) begin
      if (partial && (5'(i) >= {1'b0, rest})) begin
        plain_pad[127-8*i -: 8] = pad_val;
      end
    end
  end

  // shared datapath input: the pad block while one is owed, else the data word
  assign cv_sel = (off_eff == 32'd0) ? iv : chain;
  assign aes_in = pad_pending ? ({16{8'h10}} ^ chain) : (plain_pad ^ cv_sel);

  // unrolled cipher, key schedule alongside
  assign rk[0] = key;
  assign st[0] = aes_in ^ key;
  for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
    assign rk[r] = next_key(rk[r-1], RCON[r-1]);
    assign st[r] = aes_round(st[r-1], rk[r], r == ROUNDS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key         <= '0;
      iv          <= '0;
      msg_len     <= '0;
      chain       <= '0;
      offset      <= '0;
      pad_pending <= 1'b0;
      out_valid   <= 1'b0;
      out_status  <= ST_CONTINUE;
      out_last    <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_KEY_HIGH: key[127:64] <= cfg_ch.data;
          REG_KEY_LOW:  key[63:0]   <= cfg_ch.data;
          REG_IV_HIGH:  iv[127:64]  <= cfg_ch.data;
          REG_IV_LOW:   iv[63:0]    <= cfg_ch.data;
          REG_MSG_LEN:  msg_len     <= cfg_ch.data[31:0];
          default: ;
        endcase
      end
      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (pad_pending && out_free) begin
        // second result of a block-aligned message end
        chain       <= st[ROUNDS];
        out_data    <= st[ROUNDS];
        out_status  <= ST_FINISHED;
        out_last    <= 1'b1;
        out_valid   <= 1'b1;
        pad_pending <= 1'b0;
      end else if (in_fire) begin
        out_valid <= 1'b1;
        if (past_end) begin
          offset     <= off_eff;
          out_data   <= '0;
          out_status <= ST_FAIL;
          out_last   <= 1'b1;
        end else begin
          // saturate rather than wrap
          offset      <= end_pos[32] ? 32'hffff_ffff : end_pos[31:0];
          chain       <= st[ROUNDS];
          out_data    <= st[ROUNDS];
          out_status  <= (at_end || partial) ? ST_FINISHED : ST_CONTINUE;
          out_last    <= !at_end;
          pad_pending <= at_end;
        end
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.cipher_high = out_data[127:64];
  assign out_ch.cipher_low  = out_data[63:0];
  assign out_ch.status      = out_status;
  assign out_ch.last_of_run = out_last;

  a_pad_blocks_input: assert property (@(posedge clk) disable iff (rst)
    pad_pending |-> !in_ch.ready) else $error("input taken while pad block owed");
  a_pad_after_result: assert property (@(posedge clk) disable iff (rst)
    pad_pending |-> out_valid) else $error("pad owed with no first result");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_FAIL) |-> (out_data == '0 && out_last))
    else $error("fail result not zero");
  a_pad_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (pad_pending && out_status == ST_FINISHED))
    else $error("non-final result without pending pad");

endmodule
`default_nettype wire

// ===== test/aes_cbc_padded_encrypt_checker.sv =====
`timescale 1ns / 1ps
module aes_cbc_padded_encrypt_checker
  import aes_cbc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  aes_cbc_in_if.sink   in_mon,
  aes_cbc_out_if.sink  out_mon,
  aes_cbc_cfg_if.sink  cfg_mon,
  output int unsigned  fail_count,
  output int unsigned  pending
);

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    status_t     st;
    logic        last;
  } cipher_word_t;

  localparam logic [7:0] SB [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  logic [127:0] key_m, iv_m, chain_m;
  logic [31:0]  len_m, offset_m;
  cipher_word_t cipher_q[$];

  assign pending = cipher_q.size();

  function automatic logic [7:0] dbl(input logic [7:0] a);
    dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte-array aes-128, byte 0 at the top of the vector
  function automatic logic [127:0] encrypt_block(input logic [127:0] key, input logic [127:0] pt);
    logic [7:0] rk [0:175];
    logic [7:0] s [0:15];
    logic [7:0] n [0:15];
    logic [7:0] t [0:3];
    logic [7:0] rc, tmp;
    logic [127:0] r;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      s[i]  = pt[127-8*i -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        tmp = t[0];
        t[0] = SB[t[1]] ^ rc;
        t[1] = SB[t[2]];
        t[2] = SB[t[3]];
        t[3] = SB[tmp];
        rc = dbl(rc);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ t[j];
    end
    for (int i = 0; i < 16; i++) s[i] ^= rk[i];
    for (int rd = 1; rd <= 10; rd++) begin
      for (int i = 0; i < 16; i++) s[i] = SB[s[i]];
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) n[j+4*c] = s[j + 4*((c+j) % 4)];
      for (int c = 0; c < 4; c++) begin
        if (rd < 10) begin
          s[4*c]   = dbl(n[4*c]) ^ dbl(n[4*c+1]) ^ n[4*c+1] ^ n[4*c+2] ^ n[4*c+3];
          s[4*c+1] = n[4*c] ^ dbl(n[4*c+1]) ^ dbl(n[4*c+2]) ^ n[4*c+2] ^ n[4*c+3];
          s[4*c+2] = n[4*c] ^ n[4*c+1] ^ dbl(n[4*c+2]) ^ dbl(n[4*c+3]) ^ n[4*c+3];
          s[4*c+3] = dbl(n[4*c]) ^ n[4*c] ^ n[4*c+1] ^ n[4*c+2] ^ dbl(n[4*c+3]);
        end else begin
          for (int j = 0; j < 4; j++) s[4*c+j] = n[4*c+j];
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[16*rd+i];
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
    return r;
  endfunction

  task automatic push_chained(input logic [127:0] blk, input status_t st, input logic last);
    cipher_word_t w;
    chain_m = encrypt_block(key_m, blk ^ chain_m);
    w.hi = chain_m[127:64];
    w.lo = chain_m[63:0];
    w.st = st;
    w.last = last;
    cipher_q.push_back(w);
  endtask

  task automatic predict_block(input logic start, input logic [127:0] pt);
    cipher_word_t w;
    logic [32:0] end_ofs;
    int rest;
    logic [127:0] blk;
    blk = pt;
    if (start) offset_m = '0;
    if (offset_m >= len_m) begin
      // input past the end of the message
      w = '{hi: '0, lo: '0, st: ST_FAIL, last: 1'b1};
      cipher_q.push_back(w);
    end else begin
      if (offset_m == 0) chain_m = iv_m;
      end_ofs = {1'b0, offset_m} + 33'd16;
      rest = len_m - offset_m;
      offset_m = end_ofs[32] ? 32'hffffffff : end_ofs[31:0];
      if (end_ofs < {1'b0, len_m}) begin
        push_chained(blk, ST_CONTINUE, 1'b1);
      end else if (end_ofs == {1'b0, len_m}) begin
        push_chained(blk, ST_FINISHED, 1'b0);
        push_chained({16{8'h10}}, ST_FINISHED, 1'b1);
      end else begin
        for (int i = rest; i < 16; i++) blk[127-8*i -: 8] = 8'(16 - rest);
        push_chained(blk, ST_FINISHED, 1'b1);
      end
    end
  endtask

  always @(posedge clk) begin
    cipher_word_t exp_w;
    if (rst) begin
      key_m = '0; iv_m = '0; chain_m = '0; len_m = '0; offset_m = '0;
      cipher_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_t'(cfg_mon.index))
          REG_KEY_HIGH: key_m[127:64] = cfg_mon.data;
          REG_KEY_LOW:  key_m[63:0] = cfg_mon.data;
          REG_IV_HIGH:  iv_m[127:64] = cfg_mon.data;
          REG_IV_LOW:   iv_m[63:0] = cfg_mon.data;
          REG_MSG_LEN:  len_m = cfg_mon.data[31:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (cipher_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %h %h st %0d", out_mon.cipher_high,
                                        out_mon.cipher_low, out_mon.status);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = cipher_q.pop_front();
          if (out_mon.cipher_high !== exp_w.hi || out_mon.cipher_low !== exp_w.lo ||
              out_mon.status !== exp_w.st || out_mon.last_of_run !== exp_w.last) begin
            if (fail_count < 10)
              $display("mismatch: exp %h %h st %0d last %0d, got %h %h st %0d last %0d",
                       exp_w.hi, exp_w.lo, exp_w.st, exp_w.last, out_mon.cipher_high,
                       out_mon.cipher_low, out_mon.status, out_mon.last_of_run);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_block(in_mon.start_message, {in_mon.plain_high, in_mon.plain_low});
    end
  end

endmodule

// ===== test/aes_cbc_padded_encrypt_test.sv =====
`timescale 1ns / 1ps
module aes_cbc_padded_encrypt_test;
  import aes_cbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned fail_count, pending;
  int unsigned cycles = 0;
  int unsigned burst_left, gap_left;

  aes_cbc_in_if  in_ch();
  aes_cbc_out_if out_ch();
  aes_cbc_cfg_if cfg_ch();

  aes_cbc_padded_encrypt dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
                              .cfg_ch(cfg_ch));

  aes_cbc_padded_encrypt_checker checker_i (.clk(clk), .rst(rst), .in_mon(in_ch),
    .out_mon(out_ch), .cfg_mon(cfg_ch), .fail_count(fail_count), .pending(pending));

  always #2 clk = ~clk;

  // receiver stall pattern: quiet stretches, light random backpressure and phases of heavy random backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (cycles[9:8] == 2'd1) begin
      out_ch.ready <= 1'b1;
    end else if (cycles[9:8] == 2'd3) begin
      out_ch.ready <= ($urandom_range(0, 3) == 0);
    end else begin
      out_ch.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("aes_cbc_padded_encrypt_test NOT OK");
      $finish;
    end
  end

  // valid stays high across consecutive writes, set_message drops it after the last
  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // one word through the input channel, with burst/gap idling ahead of it
  task automatic send_block(input logic start, input logic [63:0] hi, input logic [63:0] lo);
    if (burst_left == 0) begin
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_left != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap_left) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.start_message <= start;
    in_ch.plain_high <= hi;
    in_ch.plain_low <= lo;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_message(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] v0, input logic [63:0] v1,
                             input logic [31:0] len);
    write_reg(REG_KEY_HIGH, k0);
    write_reg(REG_KEY_LOW, k1);
    write_reg(REG_IV_HIGH, v0);
    write_reg(REG_IV_LOW, v1);
    write_reg(REG_MSG_LEN, {32'h0, len});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int unsigned sent, nblk, len;
    in_ch.valid = 1'b0;
    in_ch.start_message = 1'b0;
    in_ch.plain_high = '0;
    in_ch.plain_low = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_KEY_HIGH;
    cfg_ch.data = '0;
    burst_left = 0;
    sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero length message fails at once, also straight after reset
    send_block(1'b1, '1, '1);
    send_block(1'b0, '0, '0);
    drain_idle();
    // all-zero and all-one keys, exact block boundary needs the extra pad word
    set_message('0, '0, '0, '0, 32'd16);
    send_block(1'b1, '0, '0);
    send_block(1'b0, '1, '1);
    drain_idle();
    set_message('1, '1, '1, '1, 32'd1);
    send_block(1'b1, '1, '1);
    send_block(1'b1, 64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef);
    drain_idle();
    // multi-block message ending in a partial block of fifteen bytes
    set_message(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'h0001020304050607,
                64'h08090a0b0c0d0e0f, 32'd47);
    for (int i = 0; i < 4; i++) send_block(i == 0, rand64(), rand64());
    // restart in the middle of a message
    send_block(1'b1, rand64(), rand64());
    send_block(1'b1, rand64(), rand64());
    drain_idle();
    // near-maximum length 32'hffff_fff0: offset walks on, three blocks only
    set_message(rand64(), rand64(), rand64(), rand64(), 32'hffff_fff0);
    for (int i = 0; i < 3; i++) send_block(i == 0, rand64(), rand64());
    drain_idle();

    // random messages: mostly well-formed, occasional restarts, some stray words past the end
    while (sent < 1200) begin
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = 32'hffff_fff0 - $urandom_range(0, 15);
        2, 3: len = 16 * $urandom_range(1, 8);
        default: len = $urandom_range(1, 130);
      endcase
      set_message(rand64(), rand64(), rand64(), rand64(), len);
      for (int m = 0; m < $urandom_range(1, 4); m++) begin
        nblk = (len > 200) ? $urandom_range(1, 4) : (len + 15) / 16 + $urandom_range(0, 1);
        if (nblk == 0) nblk = 1;
        if ($urandom_range(0, 7) == 0) nblk = $urandom_range(1, nblk);
        for (int b = 0; b < nblk; b++) begin
          send_block(b == 0 || $urandom_range(0, 40) == 0, rand64(), rand64());
          sent++;
        end
      end
      drain_idle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("aes_cbc_padded_encrypt_test OK");
    end else begin
      $display("aes_cbc_padded_encrypt_test NOT OK");
    end
    $finish;
  end

endmodule
